// ----- src/d2i_pkg.sv -----
// Package for the double to integer saturating converter.
// Holds target type codes, stage structs and shared constants; no dependencies.
package d2i_pkg;

  typedef enum logic [2:0] {
    TYPE_I8  = 3'd0,
    TYPE_I16 = 3'd1,
    TYPE_I32 = 3'd2,
    TYPE_I64 = 3'd3,
    TYPE_U8  = 3'd4,
    TYPE_U16 = 3'd5,
    TYPE_U32 = 3'd6,
    TYPE_U64 = 3'd7
  } target_type_t;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [10:0] EXP_BIAS     = 11'd1023;

  // Stage 1 result: decoded fields.
  typedef struct packed {
    logic        neg;
    logic        nan;
    logic        big;
    logic        zero;
    logic        left;     // exponent at or above 52: left shift
    logic [5:0]  shamt;
    logic [52:0] mant;
    logic        last;
    logic [2:0]  ttype;
  } dec_t;

  // Stage 2 result: rounded magnitude.
  typedef struct packed {
    logic        neg;
    logic        nan;
    logic        big;
    logic [63:0] mag;
    logic        last;
    logic [2:0]  ttype;
  } mag_t;

endpackage

// ----- src/d2i_if.sv -----
// Valid/ready stream interface for the converter.
// Depends on nothing; payload widths are fixed by the field list.
interface d2i_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic        is_last;
  modport source (output valid, output value_bits, output is_last, input ready);
  modport sink (input valid, input value_bits, input is_last, output ready);
endinterface

interface d2i_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_bits;
  logic        is_last_out;
  modport source (output valid, output result_bits, output is_last_out, input ready);
  modport sink (input valid, input result_bits, input is_last_out, output ready);
endinterface

// ----- src/d2i_sat.sv -----
// Saturation and sign application for one rounded magnitude.
// Depends on d2i_pkg.
module d2i_sat import d2i_pkg::*; (
  input  mag_t        m,
  output logic [63:0] res
);
  logic [63:0] umax;
  logic [63:0] smax;
  logic        is_signed;

  always_comb begin
    is_signed = ~m.ttype[2];
    case (m.ttype[1:0])
      2'd0:    begin umax = 64'hFF;               smax = 64'h7F; end
      2'd1:    begin umax = 64'hFFFF;             smax = 64'h7FFF; end
      2'd2:    begin umax = 64'hFFFF_FFFF;        smax = 64'h7FFF_FFFF; end
      default: begin umax = 64'hFFFF_FFFF_FFFF_FFFF; smax = 64'h7FFF_FFFF_FFFF_FFFF; end
    endcase
    if (m.nan) begin
      res = '0;
    end else if (!is_signed) begin
      if (m.neg) res = '0;
      else if (m.big || m.mag > umax) res = umax;
      else res = m.mag;
    end else if (!m.neg) begin
      res = (m.big || m.mag > smax) ? smax : m.mag;
    end else begin
      res = (m.big || m.mag > smax + 64'd1) ? ~smax : (64'd0 - m.mag);
    end
  end
endmodule

// ----- src/double_to_int_saturating_convert_core.sv -----
// Top level of the double to integer saturating converter.
// Depends on d2i_pkg, d2i_in_if, d2i_out_if and d2i_sat.
//
// Usage: requests arrive on in_ch (a raw binary64 pattern plus a last marker)
// and leave on out_ch as the integer of the type held in target_type, written
// through the APB port at address 0. Rounding is to nearest, ties away from
// zero; out-of-range values and infinities saturate, NaN gives zero.
//
// The datapath has three register stages: field decode, shift and round, and
// saturation. An accepted request passes through the decode, round and
// saturation registers, and out_ch.valid rises when the last of them loads.
// A new request may enter every cycle while the receiver does not stall, so
// the sustained rate is then one per cycle.
//
// Each stage carries a valid bit. A stage advances when it is empty or the
// stage after it advances, so when the receiver stalls the pipeline fills up
// and in_ch.ready falls only once every stage holds a request; nothing is
// lost or repeated. Reset clears all valid bits and sets target_type to int8.
// The type is sampled at entry, so it travels with each request.
module double_to_int_saturating_convert_core import d2i_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  d2i_in_if.sink      in_ch,
  d2i_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0] target_type;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {29'd0, target_type} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_type <= TYPE_I8;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      target_type <= pwdata[2:0];
    end
  end

  logic v1, v2, v3;
  logic adv1, adv2, adv3;
  dec_t        s1;
  mag_t        s2;
  logic [63:0] res3;
  logic        last3;

  // Each stage loads when it is empty or its content moves on.
  assign adv3 = !v3 || out_ch.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ch.ready = adv1;

  // Stage 1: decode exponent into a shift direction and amount.
  dec_t        d1;
  logic [10:0] bexp;
  logic [10:0] e;
  always_comb begin
    bexp     = in_ch.value_bits[62:52];
    e        = bexp - EXP_BIAS;
    d1       = '0;
    d1.neg   = in_ch.value_bits[63];
    d1.nan   = (bexp == EXP_ALL_ONES) && (in_ch.value_bits[51:0] != 52'd0);
    d1.mant  = {1'b1, in_ch.value_bits[51:0]};
    d1.last  = in_ch.is_last;
    d1.ttype = target_type;
    if (bexp == EXP_ALL_ONES) begin
      d1.big = 1'b1;
    end else if (bexp < 11'd1022) begin
      // Below one half, including zero and subnormals.
      d1.zero = 1'b1;
    end else if (bexp >= 11'd1087) begin
      d1.big = 1'b1;
    end else if (bexp >= 11'd1075) begin
      d1.left  = 1'b1;
      d1.shamt = e[5:0] - 6'd52;
    end else begin
      d1.shamt = 6'd52 - e[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv1) v1 <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (adv1 && in_ch.valid) s1 <= d1;
  end

  // Stage 2: shift and round half away from zero.
  mag_t        m2;
  logic [64:0] rsh;
  always_comb begin
    rsh      = {12'd0, s1.mant} << 1 >> s1.shamt;
    m2.neg   = s1.neg;
    m2.nan   = s1.nan;
    m2.big   = s1.big;
    m2.last  = s1.last;
    m2.ttype = s1.ttype;
    if (s1.zero || s1.big) m2.mag = '0;
    else if (s1.left) m2.mag = {11'd0, s1.mant} << s1.shamt;
    else m2.mag = rsh[64:1] + {63'd0, rsh[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv2) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv2 && v1) s2 <= m2;
  end

  // Stage 3: saturate to the target range.
  logic [63:0] sat;
  d2i_sat u_sat (.m(s2), .res(sat));

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv3) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      res3  <= sat;
      last3 <= s2.last;
    end
  end

  assign out_ch.valid       = v3;
  assign out_ch.result_bits = res3;
  assign out_ch.is_last_out = last3;

  // A full pipeline with a stalled receiver must refuse new requests.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while pipeline full and stalled");

  // An accepted request reaches the output stage when the receiver does not
  // stall in between.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && out_ch.ready) ##1 out_ch.ready ##1 out_ch.ready
    |=> out_ch.valid)
    else $error("request lost in pipeline");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.result_bits))
    else $error("stalled result changed");

endmodule

// ----- dv/double_to_int_saturating_convert_core_tb.sv -----
// Testbench for the double to integer saturating converter.
// Depends on d2i_pkg, d2i_if.sv and the converter top level; self-checking.
`timescale 1ns / 1ps

module double_to_int_saturating_convert_core_tb;
  import d2i_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  d2i_in_if  in_ch ();
  d2i_out_if out_ch ();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.value_bits = '0;
    in_ch.is_last = 1'b0;
    out_ch.ready = 1'b0;
  end

  double_to_int_saturating_convert_core u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Predicted results, oldest first. Each entry holds last marker and result.
  typedef struct packed {
    logic [63:0] result_bits;
    logic        is_last_out;
  } conv_result_t;

  conv_result_t  pending_results[$];
  target_type_t  cur_type;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   sink_wait = 0;
  bit            sink_stall_en = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Rounded magnitude of a finite value; big flags a magnitude of 2^64 or more.
  function automatic logic [63:0] rounded_magnitude(input logic [10:0] bexp,
                                                    input logic [51:0] frac,
                                                    output bit big);
    logic [52:0] m;
    int          e;
    int          s;
    logic [63:0] mag;
    big = 1'b0;
    if (bexp == 11'd0) return 64'd0;
    m = {1'b1, frac};
    e = int'(bexp) - 1023;
    if (e >= 64) begin
      big = 1'b1;
      return 64'd0;
    end
    if (e >= 52) return {11'd0, m} << (e - 52);
    s = 52 - e;
    if (s >= 64) return 64'd0;
    mag = {11'd0, m} >> s;
    mag = mag + (({11'd0, m} >> (s - 1)) & 64'd1);
    return mag;
  endfunction

  function automatic logic [63:0] saturating_convert(input logic [63:0] bits,
                                                     input target_type_t tt);
    logic        neg;
    logic [10:0] bexp;
    logic [51:0] frac;
    bit          big;
    logic [63:0] mag;
    logic [63:0] lim;
    int          width;
    neg = bits[63];
    bexp = bits[62:52];
    frac = bits[51:0];
    width = 8 << tt[1:0];
    if (bexp == EXP_ALL_ONES) begin
      if (frac != '0) return 64'd0;
      big = 1'b1;
      mag = 64'd0;
    end else begin
      mag = rounded_magnitude(bexp, frac, big);
    end
    if (tt[2]) begin
      lim = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
      if (neg) return 64'd0;
      if (big || mag > lim) return lim;
      return mag;
    end
    lim = (64'd1 << (width - 1)) - 64'd1;
    if (!neg) begin
      if (big || mag > lim) return lim;
      return mag;
    end
    if (big || mag > lim + 64'd1) return ~lim;
    return 64'd0 - mag;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  // Sends one request after a random idle gap, and records its prediction.
  // Valid stays high after acceptance so that requests can follow back to back.
  task automatic send_value(input logic [63:0] bits, input logic last);
    conv_result_t r;
    int unsigned  gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value_bits <= bits;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    r.result_bits = saturating_convert(bits, cur_type);
    r.is_last_out = last;
    pending_results.push_back(r);
  endtask

  // Writes target_type while the pipeline is empty.
  task automatic write_type(input logic [31:0] val);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_type = target_type_t'(val[2:0]);
  endtask

  // Receiver side: after each taken result it waits a random number of
  // cycles, with a stall-free mode for some phases.
  always @(posedge clk) begin
    int unsigned gap;
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_wait <= 0;
    end else if (!sink_stall_en) begin
      out_ch.ready <= 1'b1;
    end else if (out_ch.valid && out_ch.ready) begin
      gap = $urandom_range(0, 13);
      sink_wait <= gap;
      out_ch.ready <= (gap == 0);
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      out_ch.ready <= (sink_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Result checker: every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    conv_result_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.result_bits, 64'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_ch.result_bits !== w.result_bits)
          report_mismatch("result_bits", out_ch.result_bits, w.result_bits);
        if (out_ch.is_last_out !== w.is_last_out)
          report_mismatch("is_last_out", {63'd0, out_ch.is_last_out},
                          {63'd0, w.is_last_out});
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Special values: zeros, halves, infinities, NaN, range edges, subnormals.
  task automatic test_special_values();
    logic [63:0] vals[$];
    vals = '{64'h0000000000000000, 64'h8000000000000000, 64'h0000000000000001,
             64'h3FE0000000000000, 64'hBFE0000000000000, 64'h4004000000000000,
             64'hC004000000000000, 64'h7FF0000000000000, 64'hFFF0000000000000,
             64'h7FF8000000000001, 64'hFFFFFFFFFFFFFFFF, 64'h43E0000000000000,
             64'hC3E0000000000000, 64'h43F0000000000000, 64'h406FE00000000000,
             64'hC060200000000000, 64'h3FDFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF,
             64'h43EFFFFFFFFFFFFF, 64'h4330000000000001};
    foreach (vals[i]) send_value(vals[i], i[0]);
  endtask

  // Random values, biased toward exponents near the integer range.
  task automatic test_random_values(input int n);
    logic [63:0] v;
    for (int i = 0; i < n; i++) begin
      v = rand64();
      if ($urandom_range(0, 3) != 0)
        v[62:52] = 11'(32'd1020 + $urandom_range(0, 48));
      send_value(v, 1'($urandom_range(0, 1)));
    end
  endtask

  // Each type once, including the extremes and a write with upper bits set.
  task automatic test_all_types();
    for (int t = 0; t < 8; t++) begin
      write_type($urandom() & ~32'h7 | t);
      sink_stall_en = (t != 3);
      test_special_values();
      test_random_values(120);
    end
    sink_stall_en = 1'b1;
  endtask

  initial begin
    cur_type = TYPE_I8;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_values();
    test_all_types();
    write_type({29'd0, TYPE_U64});
    test_random_values(60);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
